@@ design/wsd_pkg.sv @@
// types and constants shared by the websocket frame deframer modules
// no dependencies; imported by every module of the block
package wsd_pkg;

   // parser phase
   typedef enum logic [2:0] {
      PH_B0  = 3'd0,
      PH_B1  = 3'd1,
      PH_EXT = 3'd2,
      PH_KEY = 3'd3,
      PH_PAY = 3'd4
   } phase_type;

   // result kind, carried on rsp_tuser
   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;
   localparam logic [3:0] EXT_BYTES_16 = 4'd2;
   localparam logic [3:0] EXT_BYTES_64 = 4'd8;
   localparam logic [2:0] KEY_BYTES = 3'd4;

   localparam int LEN_W = 63;

   // one result from the parser
   // hdr is {fin, rsv1, rsv2, rsv3, opcode, masked}
   typedef struct packed {
      logic             valid;
      kind_type         kind;
      logic [8:0]       hdr;
      logic [LEN_W-1:0] len;
      logic [7:0]       pbyte;
      logic             last;
   } res_type;

endpackage

@@ design/wsd_in_stage.sv @@
// input register of the deframer: holds one accepted stream byte
// depends on wsd_pkg
module wsd_in_stage
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_byte,
   input  logic       step,
   output logic       in_valid,
   output logic [7:0] in_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       load;

   assign req_tready = !valid_ff || step;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (step) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_byte;
      end
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

@@ design/wsd_parser.sv @@
// frame header parser, payload counter and unmasking for the deframer
// depends on wsd_pkg
module wsd_parser
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] in_byte,
   output res_type    res
);

   phase_type        phase_ff, phase_in;
   logic [3:0]       ext_left_ff, ext_left_in;
   logic             ext64_ff, ext64_in;
   logic [63:0]      acc_ff, acc_in;
   logic [31:0]      key_ff, key_in;
   logic [2:0]       key_left_ff, key_left_in;
   logic [1:0]       key_pos_ff, key_pos_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [8:0]       hdr_ff, hdr_in;

   always_comb begin
      logic [63:0]      acc_shift;
      logic [3:0]       ext_dec;
      logic [2:0]       key_dec;
      logic [LEN_W-1:0] rem_dec;
      logic [LEN_W-1:0] fin_len;
      logic [7:0]       kbyte;
      logic             length_done;
      logic             header_done;

      acc_shift   = {acc_ff[55:0], in_byte};
      ext_dec     = (ext_left_ff != 4'd0) ? ext_left_ff - 4'd1 : 4'd0;
      key_dec     = (key_left_ff != 3'd0) ? key_left_ff - 3'd1 : 3'd0;
      rem_dec     = (rem_ff != '0) ? rem_ff - LEN_W'(1) : '0;
      fin_len     = acc_ff[LEN_W-1:0];
      length_done = 1'b0;
      header_done = 1'b0;

      case (key_pos_ff)
         2'd0:    kbyte = key_ff[31:24];
         2'd1:    kbyte = key_ff[23:16];
         2'd2:    kbyte = key_ff[15:8];
         default: kbyte = key_ff[7:0];
      endcase

      phase_in    = phase_ff;
      ext_left_in = ext_left_ff;
      ext64_in    = ext64_ff;
      acc_in      = acc_ff;
      key_in      = key_ff;
      key_left_in = key_left_ff;
      key_pos_in  = key_pos_ff;
      rem_in      = rem_ff;
      hdr_in      = hdr_ff;

      res       = '0;
      res.kind  = KIND_HEADER;

      case (phase_ff)
         PH_B1: begin
            hdr_in = {hdr_ff[8:1], in_byte[7]};
            acc_in = '0;
            if (in_byte[6:0] < LEN_CODE_16) begin
               acc_in      = {57'd0, in_byte[6:0]};
               fin_len     = {56'd0, in_byte[6:0]};
               length_done = 1'b1;
            end else begin
               ext64_in    = (in_byte[6:0] == LEN_CODE_64);
               ext_left_in = (in_byte[6:0] == LEN_CODE_64) ? EXT_BYTES_64 : EXT_BYTES_16;
               phase_in    = PH_EXT;
            end
         end
         PH_EXT: begin
            acc_in      = acc_shift;
            ext_left_in = ext_dec;
            if (ext_dec == 4'd0) begin
               if (ext64_ff && acc_shift[63]) begin
                  res.valid = 1'b1;
                  res.kind  = KIND_ERROR;
                  phase_in  = PH_B0;
               end else begin
                  fin_len     = acc_shift[LEN_W-1:0];
                  length_done = 1'b1;
               end
            end
         end
         PH_KEY: begin
            key_in      = {key_ff[23:0], in_byte};
            key_left_in = key_dec;
            if (key_dec == 3'd0) begin
               header_done = 1'b1;
            end
         end
         PH_PAY: begin
            res.valid  = 1'b1;
            res.kind   = KIND_PAYLOAD;
            res.pbyte  = in_byte ^ kbyte;
            key_pos_in = key_pos_ff + 2'd1;
            rem_in     = rem_dec;
            if (rem_dec == '0) begin
               res.last = 1'b1;
               phase_in = PH_B0;
            end
         end
         default: begin
            // byte 0: fin, rsv and opcode; mask flag cleared until byte 1
            hdr_in   = {in_byte, 1'b0};
            phase_in = PH_B1;
         end
      endcase

      // length known: fetch the key if masked, else the header is done
      if (length_done) begin
         key_in = '0;
         if (hdr_in[0]) begin
            key_left_in = KEY_BYTES;
            phase_in    = PH_KEY;
         end else begin
            header_done = 1'b1;
         end
      end

      if (header_done) begin
         res.valid  = 1'b1;
         res.kind   = KIND_HEADER;
         res.len    = fin_len;
         res.last   = (fin_len == '0);
         rem_in     = fin_len;
         key_pos_in = 2'd0;
         phase_in   = (fin_len == '0) ? PH_B0 : PH_PAY;
      end

      res.hdr = hdr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_B0;
         ext_left_ff <= 4'd0;
         ext64_ff    <= 1'b0;
         key_left_ff <= 3'd0;
         key_pos_ff  <= 2'd0;
      end else if (step) begin
         phase_ff    <= phase_in;
         ext_left_ff <= ext_left_in;
         ext64_ff    <= ext64_in;
         key_left_ff <= key_left_in;
         key_pos_ff  <= key_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         acc_ff <= acc_in;
         key_ff <= key_in;
         rem_ff <= rem_in;
         hdr_ff <= hdr_in;
      end
   end

endmodule

@@ design/wsd_out_stage.sv @@
// result register of the deframer, drives the rsp_ channel
// depends on wsd_pkg
module wsd_out_stage
   import wsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  res_type     res,
   output logic        out_valid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   logic    valid_ff, valid_in;
   res_type res_ff;

   always_comb begin
      valid_in = valid_ff;
      if (step) begin
         valid_in = res.valid;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res.valid) begin
         res_ff <= res;
      end
   end

   assign out_valid = valid_ff;
   // hdr bit order {fin, rsv1, rsv2, rsv3, opcode, masked} maps to fin in bit 0 upward
   assign rsp_tdata = {res_ff.pbyte, res_ff.len, res_ff.hdr[0], res_ff.hdr[4:1],
                       res_ff.hdr[5], res_ff.hdr[6], res_ff.hdr[7], res_ff.hdr[8]};
   assign rsp_tuser = res_ff.kind;
   assign rsp_tlast = res_ff.last;

endmodule

@@ design/websocket_frame_deframer_core.sv @@
// top level of the websocket frame deframer
// depends on wsd_pkg, wsd_in_stage, wsd_parser and wsd_out_stage
//
// usage
//   req_ channel: one byte of the frame stream per request, header or payload
//   rsp_ channel: zero or one result per request byte
//     header result once the header is complete (tlast when length is zero)
//     one payload result per payload byte, unmasked with key byte (index mod 4),
//       tlast on the final byte of the frame
//     length error result when a 64-bit length has its top bit set; the parser
//       then waits for byte 0 of a new frame
//   path: a request byte is captured in the input register, then the parser's
//     result for it is captured in the result register that drives rsp_
//   throughput: one request per cycle while rsp_tready is high; the parser
//     state update is the loop that sets this
//   header bytes that give no result still pass through the parser at that rate
//   reset: synchronous, active high; clears both registers' valid flags and
//     puts the parser back to waiting for header byte 0
//   receiver stall: a held result keeps rsp_ stable; one more request sits in
//     the input register, after which req_tready drops until rsp_tready returns
module websocket_frame_deframer_core
   import wsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] fin, [1] rsv1, [2] rsv2, [3] rsv3, [7:4] opcode, [8] masked,
   // [71:9] payload_length, [79:72] payload_byte
   output logic [79:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last_of_frame
);

   logic       in_valid;
   logic [7:0] in_byte;
   logic       out_valid;
   logic       step;
   res_type    res;

   // the parser moves when it holds a byte and the result register can take
   // whatever comes out
   assign step = in_valid && (!out_valid || rsp_tready);

   wsd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .step       (step),
      .in_valid   (in_valid),
      .in_byte    (in_byte)
   );

   wsd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_byte (in_byte),
      .res     (res)
   );

   wsd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .res        (res),
      .out_valid  (out_valid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tvalid = out_valid;

endmodule

@@ design/wsd_checker.sv @@
// port-level checks on the deframer's result channel, bound to the top level
// depends on wsd_pkg and websocket_frame_deframer_core
module wsd_checker
   import wsd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp result changed while stalled");

   // header results flag the end of frame exactly when the length is zero
   a_hdr_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_HEADER |-> rsp_tlast == (rsp_tdata[71:9] == 63'd0))
      else $error("header tlast disagrees with payload length");

   // error results never close a frame and carry no length
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_ERROR |-> !rsp_tlast && rsp_tdata[79:9] == 71'd0)
      else $error("length error result carries stale fields");

   // payload results carry no length
   a_pay_nolen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_PAYLOAD |-> rsp_tdata[71:9] == 63'd0)
      else $error("payload result carries a length");

   // nothing is presented straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result presented straight after reset");

endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

@@ dv/wsd_checker.sv @@
`timescale 1ns / 100ps
// checker for the websocket frame deframer: watches both channels, predicts the result stream
// from the request bytes and compares every result field by field; depends on wsd_pkg
module wsd_scoreboard
   import wsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] fin, [1] rsv1, [2] rsv2, [3] rsv3, [7:4] opcode, [8] masked,
   // [71:9] payload_length, [79:72] payload_byte
   input  logic [79:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,   // [1:0] kind
   input  logic        rsp_tlast,   // last_of_frame
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      kind_type    kind;
      logic [8:0]  hdr;      // {fin, rsv1, rsv2, rsv3, opcode, masked}
      logic [62:0] len;
      logic [7:0]  pbyte;
      logic        last;
   } deframe_result_type;

   deframe_result_type due_results[$];
   int mismatches = 0;
   int waiting    = 0;

   assign fail_count = mismatches;
   assign pending    = waiting;

   // parser state of the prediction
   phase_type   ph;
   logic [3:0]  ext_left;
   bit          ext_64;
   logic [63:0] len_acc;
   logic [31:0] key_word;
   logic [2:0]  key_left;
   logic [1:0]  key_pos;
   logic [62:0] bytes_left;
   logic [8:0]  hdr_bits;

   function automatic deframe_result_type header_result();
      deframe_result_type r;
      r = '0;
      r.kind     = KIND_HEADER;
      r.hdr      = hdr_bits;
      r.len      = len_acc[62:0];
      r.last     = (len_acc[62:0] == '0);
      bytes_left = len_acc[62:0];
      key_pos    = 2'd0;
      ph         = r.last ? PH_B0 : PH_PAY;
      return r;
   endfunction

   // length known: either a key follows or the header is done
   function automatic bit length_known(output deframe_result_type r);
      r = '0;
      key_word = '0;
      if (hdr_bits[0]) begin
         key_left = KEY_BYTES;
         ph = PH_KEY;
         return 1'b0;
      end
      r = header_result();
      return 1'b1;
   endfunction

   function automatic bit deframe_byte(input logic [7:0] b, output deframe_result_type r);
      logic [7:0] key_byte;
      r = '0;
      r.hdr = hdr_bits;
      case (ph)
         PH_B1: begin
            hdr_bits[0] = b[7];
            len_acc = '0;
            if (b[6:0] < LEN_CODE_16) begin
               len_acc = {57'd0, b[6:0]};
               return length_known(r);
            end
            ext_64 = (b[6:0] == LEN_CODE_64);
            ext_left = ext_64 ? EXT_BYTES_64 : EXT_BYTES_16;
            ph = PH_EXT;
         end
         PH_EXT: begin
            len_acc = {len_acc[55:0], b};
            if (ext_left != 0) ext_left = ext_left - 1'b1;
            if (ext_left == 0) begin
               // 64-bit length with its top bit set
               if (ext_64 && len_acc[63]) begin
                  r.kind = KIND_ERROR;
                  ph = PH_B0;
                  return 1'b1;
               end
               return length_known(r);
            end
         end
         PH_KEY: begin
            key_word = {key_word[23:0], b};
            if (key_left != 0) key_left = key_left - 1'b1;
            if (key_left == 0) begin
               r = header_result();
               return 1'b1;
            end
         end
         PH_PAY: begin
            key_byte = key_word[8*(3-key_pos) +: 8];
            r.kind  = KIND_PAYLOAD;
            r.pbyte = b ^ key_byte;
            key_pos = key_pos + 1'b1;
            if (bytes_left != 0) bytes_left = bytes_left - 1'b1;
            if (bytes_left == 0) begin
               r.last = 1'b1;
               ph = PH_B0;
            end
            return 1'b1;
         end
         default: begin
            // byte 0; masked bit waits for byte 1
            hdr_bits = {b, 1'b0};
            ph = PH_B1;
         end
      endcase
      return 1'b0;
   endfunction

   function automatic void check_field(string name, logic [62:0] want, logic [62:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      deframe_result_type want;
      deframe_result_type got;
      if (reset) begin
         ph         = PH_B0;
         ext_left   = '0;
         ext_64     = 1'b0;
         len_acc    = '0;
         key_word   = '0;
         key_left   = '0;
         key_pos    = '0;
         bytes_left = '0;
         hdr_bits   = '0;
         due_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               $error("result with nothing expected: kind 0x%0h data 0x%0h",
                      rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = due_results.pop_front();
               check_field("kind", want.kind, rsp_tuser);
               check_field("fin", want.hdr[8], rsp_tdata[0]);
               check_field("rsv1", want.hdr[7], rsp_tdata[1]);
               check_field("rsv2", want.hdr[6], rsp_tdata[2]);
               check_field("rsv3", want.hdr[5], rsp_tdata[3]);
               check_field("opcode", want.hdr[4:1], rsp_tdata[7:4]);
               check_field("masked", want.hdr[0], rsp_tdata[8]);
               check_field("payload_length", want.len, rsp_tdata[71:9]);
               check_field("payload_byte", want.pbyte, rsp_tdata[79:72]);
               check_field("last_of_frame", want.last, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready && deframe_byte(req_tdata, got))
            due_results.push_back(got);
      end
      waiting <= due_results.size();
   end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// testbench top for websocket_frame_deframer_core: drives frame byte streams with random
// idling and stalls and gives the verdict; depends on wsd_pkg and wsd_scoreboard
module tb_top
   import wsd_pkg::*;
();

   localparam int STREAM_BYTES   = 1200;
   localparam int WATCHDOG_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] stream_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [0] fin, [1] rsv1, [2] rsv2, [3] rsv3, [7:4] opcode, [8] masked,
   // [71:9] payload_length, [79:72] payload_byte
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;        // [1:0] kind
   logic        rsp_tlast;        // last_of_frame

   int fail_count;
   int pending;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int bytes_sent    = 0;
   int quiet_cycles  = 0;

   logic [7:0] stream_q[$];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   websocket_frame_deframer_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   wsd_scoreboard chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // receiver stalls at the rate of the current idling mode
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // ends the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(255));
   endfunction

   // one frame with random header bits and content; mostly short payloads,
   // some non-minimal 16/64-bit lengths and some length errors
   function automatic void add_random_frame();
      logic [7:0]  b;
      logic [63:0] len;
      bit          masked;
      int          form;
      masked = 1'($urandom_range(1));
      form = $urandom_range(99);
      stream_q.push_back(rand_byte());
      if (form < 60) begin
         len = ($urandom_range(9) == 0) ? 64'($urandom_range(125))
                                         : 64'($urandom_range(16));
         stream_q.push_back({masked, len[6:0]});
      end else if (form < 80) begin
         len = 64'($urandom_range(40));
         stream_q.push_back({masked, LEN_CODE_16});
         stream_q.push_back(len[15:8]);
         stream_q.push_back(len[7:0]);
      end else if (form < 90) begin
         len = 64'($urandom_range(40));
         stream_q.push_back({masked, LEN_CODE_64});
         for (int i = 7; i >= 0; i--) stream_q.push_back(len[8*i +: 8]);
      end else begin
         // top length bit set: error result, no key and no payload follow
         b = rand_byte();
         stream_q.push_back({masked, LEN_CODE_64});
         stream_q.push_back({1'b1, b[6:0]});
         repeat (7) stream_q.push_back(rand_byte());
         return;
      end
      if (masked) repeat (4) stream_q.push_back(rand_byte());
      repeat (len) stream_q.push_back(rand_byte());
   endfunction

   // hands the queued bytes over one request at a time; tvalid stays high
   // between back-to-back requests
   task automatic send_stream();
      while (stream_q.size() != 0) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= stream_q.pop_front();
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         bytes_sent++;
      end
   endtask

   initial begin
      logic [7:0] b;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // masked length error: the next byte is taken as a new byte 0
      stream_q.push_back(8'hF8);
      stream_q.push_back(8'hFF);
      stream_q.push_back(8'h80);
      repeat (7) stream_q.push_back(8'hFF);
      // non-minimal 16-bit length of 5, masked, key covers all four positions
      stream_q.push_back(8'h81);
      stream_q.push_back({1'b1, LEN_CODE_16});
      stream_q.push_back(8'h00);
      stream_q.push_back(8'h05);
      stream_q.push_back(8'hFF);
      stream_q.push_back(8'h00);
      stream_q.push_back(8'hA5);
      stream_q.push_back(8'h5A);
      stream_q.push_back(8'h00);
      stream_q.push_back(8'hFF);
      stream_q.push_back(8'h3C);
      stream_q.push_back(8'hC3);
      stream_q.push_back(8'h5A);
      // zero-length unmasked frame
      stream_q.push_back(8'h00);
      stream_q.push_back(8'h00);
      send_stream();

      while (bytes_sent < STREAM_BYTES) begin
         case ((bytes_sent / 150) % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 54; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 54; end
            default: begin send_idle_pct = 21; stall_pct = 21; end
         endcase
         add_random_frame();
         send_stream();
      end

      // largest legal length, masked; the stream stops partway into its payload
      b = rand_byte();
      stream_q.push_back(b);
      stream_q.push_back({1'b1, LEN_CODE_64});
      stream_q.push_back(8'h7F);
      repeat (7) stream_q.push_back(8'hFF);
      repeat (4) stream_q.push_back(rand_byte());
      repeat (12) stream_q.push_back(rand_byte());
      send_stream();
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
